// ----- rtl/core/tga_rle_pkg.sv -----
// Shared types and constants for the TGA run-length decoder.
package tga_rle_pkg;

    // Packet header split point and the offset applied to run headers.
    localparam int MAX_PACKET_PIXELS = 128;
    localparam logic [7:0] RUN_OFFSET = 8'(MAX_PACKET_PIXELS - 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_COUNT     = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [2:0] BPP_RESET = 3'd4;

    // Decoder phases.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_PIXEL  = 2'd2,
        PH_ERROR  = 2'd3
    } phase_t;

    // Per-packet decode state, everything except the frame pixel counter.
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  packet_left;
        logic [7:0]  run_count;
        logic [1:0]  byte_pos;
        logic [31:0] assembly;
    } dec_state_t;

    // One result item.
    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        frame_done;
        logic        overflow_error;
    } result_t;

endpackage

// ----- rtl/core/tga_rle_step.sv -----
// Combinational next-state and result logic for one stream byte.
module tga_rle_step #(
    parameter int PIXEL_COUNT_BITS = 25
) (
    input  tga_rle_pkg::dec_state_t      cur_state,
    input  logic [PIXEL_COUNT_BITS-1:0]  cur_remaining,
    input  logic [PIXEL_COUNT_BITS-1:0]  pixel_count,
    input  logic [2:0]                   bytes_per_pixel,
    input  logic [7:0]                   data_byte,
    input  logic                         frame_start,
    output tga_rle_pkg::dec_state_t      nxt_state,
    output logic [PIXEL_COUNT_BITS-1:0]  nxt_remaining,
    output logic                         res_valid,
    output tga_rle_pkg::result_t         res
);
    import tga_rle_pkg::*;

    dec_state_t                  eff_state;
    logic [PIXEL_COUNT_BITS-1:0] eff_remaining;
    logic                        raw_packet;
    logic [7:0]                  pkt_pixels;
    logic                        too_large;
    logic [31:0]                 assembled;
    logic [2:0]                  bpp_eff;
    logic                        pixel_done;
    logic [7:0]                  rep;
    logic [PIXEL_COUNT_BITS-1:0] rem_after;
    logic                        frame_end;
    logic [7:0]                  left_after;

    // A frame start clears the packet state and reloads the pixel counter.
    always_comb begin
        eff_state     = cur_state;
        eff_remaining = cur_remaining;
        if (frame_start) begin
            eff_state.phase       = PH_HEADER;
            eff_state.packet_left = '0;
            eff_state.run_count   = '0;
            eff_state.byte_pos    = '0;
            eff_state.assembly    = '0;
            eff_remaining         = pixel_count;
        end
    end

    // Header decode: raw packets hold header+1 pixels, run packets header-127.
    assign raw_packet = ~data_byte[7];
    assign pkt_pixels = raw_packet ? (data_byte + 8'd1) : (data_byte - RUN_OFFSET);
    assign too_large  = PIXEL_COUNT_BITS'(pkt_pixels) > eff_remaining;

    // Pixel byte gathering, first byte in the low bits.
    assign assembled = eff_state.assembly | (32'(data_byte) << {eff_state.byte_pos, 3'b000});

    // Out-of-range widths clamp to one or four bytes.
    always_comb begin
        if (bytes_per_pixel == 3'd0) begin
            bpp_eff = 3'd1;
        end else if (bytes_per_pixel > 3'd4) begin
            bpp_eff = 3'd4;
        end else begin
            bpp_eff = bytes_per_pixel;
        end
    end

    assign pixel_done = ({1'b0, eff_state.byte_pos} + 3'd1) >= bpp_eff;

    // Pixel accounting for a completed pixel.
    assign rep        = (eff_state.run_count == 8'd0) ? 8'd1 : eff_state.run_count;
    assign rem_after  = (eff_remaining >= PIXEL_COUNT_BITS'(rep)) ?
                        (eff_remaining - PIXEL_COUNT_BITS'(rep)) : '0;
    assign frame_end  = (rem_after == '0);
    assign left_after = (eff_state.packet_left != 8'd0) ?
                        (eff_state.packet_left - 8'd1) : 8'd0;

    // Next state.
    always_comb begin
        nxt_state     = eff_state;
        nxt_remaining = eff_remaining;
        unique case (eff_state.phase)
            PH_HEADER: begin
                if (too_large) begin
                    nxt_state.phase = PH_ERROR;
                end else begin
                    nxt_state.packet_left = raw_packet ? pkt_pixels : 8'd1;
                    nxt_state.run_count   = raw_packet ? 8'd0 : pkt_pixels;
                    nxt_state.byte_pos    = '0;
                    nxt_state.assembly    = '0;
                    nxt_state.phase       = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                if (!pixel_done) begin
                    nxt_state.assembly = assembled;
                    nxt_state.byte_pos = eff_state.byte_pos + 2'd1;
                end else begin
                    nxt_remaining         = rem_after;
                    nxt_state.byte_pos    = '0;
                    nxt_state.assembly    = '0;
                    nxt_state.packet_left = left_after;
                    if (frame_end) begin
                        nxt_state.phase       = PH_IDLE;
                        nxt_state.packet_left = '0;
                        nxt_state.run_count   = '0;
                    end else if (left_after == 8'd0) begin
                        nxt_state.phase     = PH_HEADER;
                        nxt_state.run_count = '0;
                    end
                end
            end
            PH_IDLE: begin
                nxt_state = eff_state;
            end
            PH_ERROR: begin
                nxt_state = eff_state;
            end
        endcase
    end

    // Result for this byte, if it produces one.
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        unique case (eff_state.phase)
            PH_HEADER: begin
                if (too_large) begin
                    res_valid          = 1'b1;
                    res.overflow_error = 1'b1;
                end
            end
            PH_PIXEL: begin
                if (pixel_done) begin
                    res_valid        = 1'b1;
                    res.pixel_value  = assembled;
                    res.repeat_count = rep;
                    res.frame_done   = frame_end;
                end
            end
            PH_IDLE: begin
                res_valid = 1'b0;
            end
            PH_ERROR: begin
                res_valid = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/tga_rle_decoder.sv -----
// Top level of the TGA run-length packet decoder.
//
//   Channel   Direction  Handshake          Payload
//   cfg       in         cfg_wen            cfg_index, cfg_wdata
//   s         in         s_valid/s_ready    s_data_byte, s_frame_start
//   m         out        m_valid/m_ready    m_pixel_value, m_repeat_count,
//                                           m_frame_done, m_overflow_error
//
// One byte is taken per clock while s_ready is high; each byte's result,
// if any, appears in the output register in the cycle after it is accepted.
// The single output register sets the rate: a new byte is accepted whenever
// that register is empty or being emptied in the same cycle.
// Reset is synchronous and active low; it idles the decoder until a frame start.
// A stalled result holds the input side, so no byte is lost.
module tga_rle_decoder #(
    parameter int PIXEL_COUNT_BITS = 25
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wen,
    input  logic [tga_rle_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [PIXEL_COUNT_BITS-1:0]             cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [7:0]                              s_data_byte,
    input  logic                                    s_frame_start,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [31:0]                             m_pixel_value,
    output logic [7:0]                              m_repeat_count,
    output logic                                    m_frame_done,
    output logic                                    m_overflow_error
);
    import tga_rle_pkg::*;

    logic [2:0]                  bpp_reg;
    logic [PIXEL_COUNT_BITS-1:0] pixel_count_reg;
    dec_state_t                  state_reg;
    dec_state_t                  state_next;
    logic [PIXEL_COUNT_BITS-1:0] remaining_reg;
    logic [PIXEL_COUNT_BITS-1:0] remaining_next;
    logic                        res_valid;
    result_t                     res;
    logic                        m_valid_reg;
    result_t                     result_reg;
    logic                        accept;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg         <= BPP_RESET;
            pixel_count_reg <= PIXEL_COUNT_BITS'(1);
        end else if (cfg_wen) begin
            if (cfg_index == REG_BYTES_PER_PIXEL) begin
                bpp_reg <= cfg_wdata[2:0];
            end else if (cfg_index == REG_PIXEL_COUNT) begin
                pixel_count_reg <= cfg_wdata;
            end
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    tga_rle_step #(
        .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
    ) u_step (
        .cur_state       (state_reg),
        .cur_remaining   (remaining_reg),
        .pixel_count     (pixel_count_reg),
        .bytes_per_pixel (bpp_reg),
        .data_byte       (s_data_byte),
        .frame_start     (s_frame_start),
        .nxt_state       (state_next),
        .nxt_remaining   (remaining_next),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Decoder state advances on every accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= PH_IDLE;
            state_reg.packet_left <= '0;
            state_reg.run_count   <= '0;
            state_reg.byte_pos    <= '0;
            state_reg.assembly    <= '0;
            remaining_reg         <= '0;
        end else if (accept) begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
        end
    end

    // Output register: loaded with a result, cleared once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            result_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pixel_value    = result_reg.pixel_value;
    assign m_repeat_count   = result_reg.repeat_count;
    assign m_frame_done     = result_reg.frame_done;
    assign m_overflow_error = result_reg.overflow_error;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the TGA run-length packet decoder.
`timescale 1ns / 100ps

module tb_top;
    import tga_rle_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1000;

    // Scoreboard: predicts each decoded pixel and checks the results in order.
    class pixel_scoreboard;
        logic [2:0]  bpp_reg;
        logic [24:0] pixel_count;
        phase_t      phase;
        logic [7:0]  pkt_left;
        logic [7:0]  run_len;
        logic [1:0]  byte_pos;
        logic [31:0] assembly;
        logic [24:0] remaining;
        result_t     expected_pixels[$];
        int          failures;

        function new();
            bpp_reg = BPP_RESET;
            pixel_count = 25'd1;
            phase = PH_IDLE;
            pkt_left = '0;
            run_len = '0;
            byte_pos = '0;
            assembly = '0;
            remaining = '0;
            failures = 0;
        endfunction

        // Out-of-range settings clamp to the nearest legal byte count.
        function int eff_bpp();
            if (bpp_reg == 3'd0) return 1;
            if (bpp_reg > 3'd4) return 4;
            return int'(bpp_reg);
        endfunction

        function void note_config(logic [CFG_INDEX_BITS-1:0] idx, logic [24:0] data);
            if (idx == REG_BYTES_PER_PIXEL) bpp_reg = data[2:0];
            else if (idx == REG_PIXEL_COUNT) pixel_count = data;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Advances the decode state by one accepted item; returns 0 if it was dropped.
        function bit note_byte(logic [7:0] b, logic fs);
            result_t r;
            int      n;
            int      rep;
            bit      raw;
            r = '0;
            if (fs) begin
                phase = PH_HEADER;
                pkt_left = '0;
                run_len = '0;
                byte_pos = '0;
                assembly = '0;
                remaining = pixel_count;
            end
            case (phase)
                PH_HEADER: begin
                    raw = (b < MAX_PACKET_PIXELS);
                    n = raw ? int'(b) + 1 : int'(b) - int'(RUN_OFFSET);
                    if (n > int'(remaining)) begin
                        // The packet cannot fit in what is left of the frame.
                        phase = PH_ERROR;
                        r.overflow_error = 1'b1;
                        expected_pixels.push_back(r);
                    end else begin
                        pkt_left = 8'(raw ? n : 1);
                        run_len = 8'(raw ? 0 : n);
                        byte_pos = '0;
                        assembly = '0;
                        phase = PH_PIXEL;
                    end
                    return 1'b1;
                end
                PH_PIXEL: begin
                    assembly |= 32'(b) << (8 * byte_pos);
                    if (int'(byte_pos) + 1 < eff_bpp()) begin
                        byte_pos++;
                        return 1'b1;
                    end
                    rep = (run_len == 8'd0) ? 1 : int'(run_len);
                    remaining = (int'(remaining) >= rep) ? remaining - 25'(rep) : '0;
                    r.pixel_value = assembly;
                    r.repeat_count = 8'(rep);
                    r.frame_done = (remaining == '0);
                    expected_pixels.push_back(r);
                    byte_pos = '0;
                    assembly = '0;
                    pkt_left = (pkt_left > 8'd0) ? pkt_left - 8'd1 : 8'd0;
                    if (r.frame_done) begin
                        phase = PH_IDLE;
                        pkt_left = '0;
                        run_len = '0;
                    end else if (pkt_left == 8'd0) begin
                        phase = PH_HEADER;
                        run_len = '0;
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_pixel(logic [31:0] value, logic [7:0] rep, logic done,
                                  logic err);
            result_t want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result item: value 0x%0h repeat %0d", value, rep);
                failures++;
                return;
            end
            want = expected_pixels.pop_front();
            check_field("pixel_value", want.pixel_value, value);
            check_field("repeat_count", 32'(want.repeat_count), 32'(rep));
            check_field("frame_done", 32'(want.frame_done), 32'(done));
            check_field("overflow_error", 32'(want.overflow_error), 32'(err));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_BYTES_PER_PIXEL;
    logic [24:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_frame_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_pixel_value;
    logic [7:0]  m_repeat_count;
    logic        m_frame_done;
    logic        m_overflow_error;

    pixel_scoreboard sb = new();
    bit no_idle = 1'b0;
    int decoded_items = 0;
    int cycles = 0;

    tga_rle_decoder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_frame_start    (s_frame_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_value    (m_pixel_value),
        .m_repeat_count   (m_repeat_count),
        .m_frame_done     (m_frame_done),
        .m_overflow_error (m_overflow_error)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tga_rle_decoder verification failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_frame_start <= fs;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (sb.note_byte(b, fs)) decoded_items++;
    endtask

    // Stops offering items and waits until every predicted result has arrived.
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic configure(input logic [2:0] bpp, input logic [24:0] count);
        cfg_wen <= 1'b1;
        cfg_index <= REG_BYTES_PER_PIXEL;
        cfg_wdata <= 25'(bpp);
        @(posedge aclk);
        sb.note_config(REG_BYTES_PER_PIXEL, 25'(bpp));
        cfg_index <= REG_PIXEL_COUNT;
        cfg_wdata <= count;
        @(posedge aclk);
        sb.note_config(REG_PIXEL_COUNT, count);
        cfg_wen <= 1'b0;
    endtask

    task automatic send_noise(input int count);
        repeat (count) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    // Sends a frame of random packets; some frames break off early or end in an oversized header.
    task automatic send_frame(input int max_packets);
        int rem;
        int n;
        int e;
        int cap;
        int len;
        int packets;
        bit run;
        bit first;
        bit trunc;
        rem = int'(sb.pixel_count);
        e = sb.eff_bpp();
        packets = 0;
        first = 1'b1;
        if (rem == 0) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            return;
        end
        while (rem > 0 && packets < max_packets) begin
            cap = (rem < MAX_PACKET_PIXELS) ? rem : MAX_PACKET_PIXELS;
            // Now and then a header that claims more pixels than the frame has left.
            if (cap < MAX_PACKET_PIXELS && $urandom_range(0, 24) == 0) begin
                n = $urandom_range(cap + 1, MAX_PACKET_PIXELS);
                run = ($urandom_range(0, 1) == 1);
                send_byte(run ? 8'(n + int'(RUN_OFFSET)) : 8'(n - 1), first);
                return;
            end
            if ($urandom_range(0, 99) < 85) n = $urandom_range(1, (cap < 8) ? cap : 8);
            else n = $urandom_range(1, cap);
            run = ($urandom_range(0, 1) == 1);
            send_byte(run ? 8'(n + int'(RUN_OFFSET)) : 8'(n - 1), first);
            first = 1'b0;
            len = run ? e : n * e;
            // A packet cut short leaves the decoder mid-packet until the next frame start.
            trunc = ($urandom_range(0, 39) == 0);
            if (trunc) len = $urandom_range(0, len - 1);
            repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
            if (trunc) return;
            rem -= n;
            packets++;
        end
    endtask

    // Result side: random stalls plus one long hold-off that backs up the input.
    initial begin : result_sink
        int stall_left;
        int results_seen;
        bit hold_done;
        stall_left = 0;
        results_seen = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                sb.check_pixel(m_pixel_value, m_repeat_count, m_frame_done,
                               m_overflow_error);
                results_seen++;
            end
            if (!hold_done && results_seen == 40) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                m_ready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Stimulus: directed cases first, then random phases with fresh settings.
    initial begin : stimulus
        int          frames;
        int          r;
        logic [2:0]  bpp_pick;
        logic [24:0] count_pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: a stray byte while idle, a one-pixel frame, a byte after it.
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h33, 1'b0);

        // Zero pixel count: the first header overflows and the block drops bytes.
        wait_drain();
        configure(3'd1, 25'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);

        // Zero bytes per pixel acts as one; largest run, then an oversized run.
        wait_drain();
        configure(3'd0, 25'd130);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hA5, 1'b0);
        // Frame start in the middle of a raw packet, then the largest raw header.
        send_byte(8'h01, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h7F, 1'b1);

        // Bytes per pixel above four acts as four; a run that ends the frame.
        wait_drain();
        configure(3'd7, 25'd2);
        send_byte(8'h81, 1'b1);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hDE, 1'b0);

        decoded_items = 0;
        while (decoded_items < RANDOM_ITEMS) begin
            wait_drain();
            r = $urandom_range(0, 9);
            if (r < 7) begin
                case ($urandom_range(0, 2))
                    0: bpp_pick = 3'd1;
                    1: bpp_pick = 3'd3;
                    default: bpp_pick = 3'd4;
                endcase
            end else begin
                bpp_pick = 3'($urandom_range(0, 7));
            end
            r = $urandom_range(0, 99);
            if (r < 4) count_pick = 25'd0;
            else if (r < 7) count_pick = 25'h1000000;
            else if (r < 9) count_pick = 25'h1FFFFFF;
            else if (r < 35) count_pick = 25'($urandom_range(1, 4));
            else count_pick = 25'($urandom_range(5, 150));
            configure(bpp_pick, count_pick);
            no_idle = ($urandom_range(0, 4) == 0);
            frames = $urandom_range(1, 3);
            repeat (frames) begin
                if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6));
                send_frame((count_pick > 25'd1000) ? 12 : 64);
            end
        end

        no_idle = 1'b0;
        wait_drain();
        repeat (10) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tga_rle_decoder verification clean");
        end else begin
            $display("tga_rle_decoder verification failed");
        end
        $finish;
    end
endmodule
